@@ sv/cdes_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the month table of the civil date to epoch seconds core.
package cdes_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int FIELD_W  = 7;
	localparam int WORD_W   = 32;
	localparam int DBM_W    = 9;
	localparam int TOD_W    = 20;
	localparam int QUOT_W   = 8;
	localparam int YDAYS_W  = 23;
	localparam int LEAPS_W  = 12;

	localparam int MONTH_FIRST = 1;
	localparam int MONTH_FEB   = 2;
	localparam int MONTH_LAST  = 12;

	localparam int DAYS_PER_YEAR  = 365;
	localparam int SECS_PER_DAY   = 86400;
	localparam int SECS_PER_HOUR  = 3600;
	localparam int SECS_PER_MIN   = 60;

	// floor(n / 100) == (n * RECIP100) >> RECIP_SHIFT for every 14-bit n
	localparam int RECIP_W     = 20;
	localparam int RECIP100    = 671089;
	localparam int RECIP_SHIFT = 26;
	localparam int CENTURY     = 100;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [FIELD_W-1:0] day;
		logic [FIELD_W-1:0] hour;
		logic [FIELD_W-1:0] minute;
		logic [FIELD_W-1:0] second;
		logic [WORD_W-1:0]  current_clock;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] epoch_seconds;
		logic [WORD_W-1:0] new_offset;
		logic              bad_date;
	} rsp_t;

	// Classified request, as held in the queue between front and back.
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [FIELD_W-1:0] day;
		logic [DBM_W-1:0]   dbm;
		logic               past_feb;
		logic [TOD_W-1:0]   tod;
		logic [WORD_W-1:0]  now;
		logic               bad;
	} work_t;

	// Days before the month in a common year.
	function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
		logic [DBM_W-1:0] d;
		case (month)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

@@ sv/cdes_front.sv @@
`timescale 1ns / 1ps
// Front end: checks the month, looks up days before the month and sums the time of day.
module cdes_front (
	input  cdes_pkg::req_t  req,
	output cdes_pkg::work_t work
);

	logic [cdes_pkg::TOD_W-1:0] hour_secs;
	logic [cdes_pkg::TOD_W-1:0] min_secs;

	assign hour_secs = cdes_pkg::TOD_W'(req.hour) * cdes_pkg::TOD_W'(cdes_pkg::SECS_PER_HOUR);
	assign min_secs  = cdes_pkg::TOD_W'(req.minute) * cdes_pkg::TOD_W'(cdes_pkg::SECS_PER_MIN);

	always_comb begin
		work.year     = req.year;
		work.day      = req.day;
		work.dbm      = cdes_pkg::days_before_month(req.month);
		work.past_feb = (req.month > cdes_pkg::MONTH_W'(cdes_pkg::MONTH_FEB));
		work.tod      = hour_secs + min_secs + cdes_pkg::TOD_W'(req.second);
		work.now      = req.current_clock;
		work.bad      = !(req.month inside {[cdes_pkg::MONTH_FIRST:cdes_pkg::MONTH_LAST]});
	end

endmodule

@@ sv/cdes_queue.sv @@
`timescale 1ns / 1ps
// Short queue of classified requests between the front and the back.
module cdes_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cdes_pkg::work_t wdata,
	output logic            full,
	input  logic            pop,
	output cdes_pkg::work_t rdata,
	output logic            avail
);

	localparam int PTR_W = $clog2(cdes_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(cdes_pkg::QUEUE_DEPTH + 1);

	cdes_pkg::work_t   entry_q [cdes_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full  = (count_q == CNT_W'(cdes_pkg::QUEUE_DEPTH));
	assign avail = (count_q != '0);
	assign rdata = entry_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(cdes_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ sv/cdes_back.sv @@
`timescale 1ns / 1ps
// Back end: sequencer that counts days, scales to seconds and updates the clock offset.
module cdes_back #(
	parameter int EPOCH_YEAR = 1970
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cdes_pkg::work_t               q_data,
	input  logic                          q_avail,
	output logic                          q_pop,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output cdes_pkg::rsp_t                rsp,
	output logic [cdes_pkg::WORD_W-1:0]   offset
);

	localparam int EPOCH_LEAPS = (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100
	                           + (EPOCH_YEAR - 1) / 400;
	localparam int PROD_W = cdes_pkg::YEAR_W + cdes_pkg::RECIP_W;
	localparam int DSEC_W = cdes_pkg::WORD_W + 17;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_QA    = 8'b0000_0010,
		ST_QB    = 8'b0000_0100,
		ST_YDAYS = 8'b0000_1000,
		ST_SUM   = 8'b0001_0000,
		ST_MUL   = 8'b0010_0000,
		ST_TOD   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t                            state_q;
	cdes_pkg::work_t                   w_q;
	logic [cdes_pkg::QUOT_W-1:0]       qa_q;
	logic [cdes_pkg::QUOT_W-1:0]       qb_q;
	logic                              leap_q;
	logic [cdes_pkg::YDAYS_W-1:0]      ydays_q;
	logic [cdes_pkg::WORD_W-1:0]       acc_q;
	logic [cdes_pkg::WORD_W-1:0]       offset_q;
	cdes_pkg::rsp_t                    rsp_q;
	logic                              rsp_valid_q;

	logic [cdes_pkg::YEAR_W-1:0]       year_m1;
	logic [cdes_pkg::YEAR_W-1:0]       div_in;
	logic [PROD_W-1:0]                 div_prod;
	logic [cdes_pkg::QUOT_W-1:0]       quot;
	logic                              cent_year;
	logic [cdes_pkg::LEAPS_W-1:0]      leaps;
	logic [cdes_pkg::YEAR_W-1:0]       nyears;
	logic [cdes_pkg::YDAYS_W-1:0]      ydays;
	logic [DSEC_W-1:0]                 day_secs;
	logic                              out_free;
	logic [cdes_pkg::WORD_W-1:0]       uptime;

	assign year_m1 = w_q.year - cdes_pkg::YEAR_W'(1);

	// One reciprocal multiplier, shared by year/100 and (year-1)/100
	assign div_in   = (state_q == ST_QA) ? w_q.year : year_m1;
	assign div_prod = PROD_W'(div_in) * PROD_W'(cdes_pkg::RECIP100);
	assign quot     = div_prod[cdes_pkg::RECIP_SHIFT +: cdes_pkg::QUOT_W];

	assign cent_year = (w_q.year == cdes_pkg::YEAR_W'(cdes_pkg::YEAR_W'(qa_q)
	                                 * cdes_pkg::YEAR_W'(cdes_pkg::CENTURY)));

	assign leaps = cdes_pkg::LEAPS_W'(year_m1 >> 2) - cdes_pkg::LEAPS_W'(qb_q)
	             + cdes_pkg::LEAPS_W'(qb_q >> 2);
	assign nyears = w_q.year - cdes_pkg::YEAR_W'(EPOCH_YEAR);
	assign ydays  = cdes_pkg::YDAYS_W'(cdes_pkg::YDAYS_W'(nyears)
	              * cdes_pkg::YDAYS_W'(cdes_pkg::DAYS_PER_YEAR))
	              + cdes_pkg::YDAYS_W'(leaps) - cdes_pkg::YDAYS_W'(EPOCH_LEAPS);

	assign day_secs = DSEC_W'(acc_q) * DSEC_W'(cdes_pkg::SECS_PER_DAY);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign uptime   = w_q.now - offset_q;

	assign q_pop     = (state_q == ST_IDLE) && q_avail;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign offset    = offset_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_avail) begin
					w_q <= q_data;
				end
			end
			ST_QA: begin
				qa_q <= quot;
			end
			ST_QB: begin
				qb_q   <= quot;
				leap_q <= ((w_q.year[1:0] == 2'b00) && !cent_year)
				       || (cent_year && (qa_q[1:0] == 2'b00));
			end
			ST_YDAYS: begin
				ydays_q <= (w_q.year > cdes_pkg::YEAR_W'(EPOCH_YEAR)) ? ydays : '0;
			end
			ST_SUM: begin
				acc_q <= cdes_pkg::WORD_W'(ydays_q) + cdes_pkg::WORD_W'(w_q.dbm)
				       + cdes_pkg::WORD_W'(leap_q && w_q.past_feb)
				       + cdes_pkg::WORD_W'(w_q.day) - cdes_pkg::WORD_W'(1);
			end
			ST_MUL: begin
				acc_q <= day_secs[cdes_pkg::WORD_W-1:0];
			end
			ST_TOD: begin
				acc_q <= acc_q + cdes_pkg::WORD_W'(w_q.tod);
			end
			ST_DONE: begin
				if (out_free) begin
					if (w_q.bad) begin
						rsp_q.epoch_seconds <= '0;
						rsp_q.new_offset    <= offset_q;
						rsp_q.bad_date      <= 1'b1;
					end else begin
						rsp_q.epoch_seconds <= acc_q;
						rsp_q.new_offset    <= acc_q - uptime;
						rsp_q.bad_date      <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			offset_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// drop the beat once taken, unless a new one loads behind it
			if (rsp_valid_q && !rsp_stall && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_avail) begin
						state_q <= q_data.bad ? ST_DONE : ST_QA;
					end
				end
				ST_QA:    state_q <= ST_QB;
				ST_QB:    state_q <= ST_YDAYS;
				ST_YDAYS: state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_TOD;
				ST_TOD:   state_q <= ST_DONE;
				ST_DONE: begin
					// hold until the output register can take the beat
					if (out_free) begin
						if (!w_q.bad) begin
							offset_q <= acc_q - uptime;
						end
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ sv/civil_date_to_epoch_seconds_core.sv @@
`timescale 1ns / 1ps
// Top level of the civil date to epoch seconds core.
// Each request beat carries a decimal date, time of day and the present clock reading; each
// yields exactly one result beat with the target time in seconds since January 1 of
// EPOCH_YEAR (modulo 2^32), the clock offset after the request and a bad-date flag for a
// month outside 1 to 12, in which case the offset is kept. The front end classifies a
// request in the cycle it is accepted and places it in a two-entry queue; the back end
// works through it with one shared reciprocal multiplier and one day-to-seconds multiply.
// A valid request steps the back-end sequencer through QA, QB, YDAYS, SUM, MUL, TOD and DONE,
// a bad date goes straight to DONE, and a new request leaves the queue only in idle. Results
// wait in an output register, and the queue keeps taking requests while a result is stalled.
module civil_date_to_epoch_seconds_core #(
	parameter int EPOCH_YEAR = 1970
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  cdes_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output cdes_pkg::rsp_t rsp
);

	cdes_pkg::work_t                 front_work;
	cdes_pkg::work_t                 head;
	logic                            q_full;
	logic                            q_avail;
	logic                            q_pop;
	logic [cdes_pkg::WORD_W-1:0]     offset;

	cdes_front u_front (
		.req  (req),
		.work (front_work)
	);

	cdes_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (req_valid && !q_full),
		.wdata  (front_work),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (head),
		.avail  (q_avail)
	);

	assign req_stall = q_full;

	cdes_back #(
		.EPOCH_YEAR (EPOCH_YEAR)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (head),
		.q_avail   (q_avail),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.offset    (offset)
	);

	a_bad_date_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.bad_date |-> rsp.epoch_seconds == '0)
		else $error("bad date result carries a nonzero time");

	a_offset_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.new_offset == offset)
		else $error("reported offset differs from the held offset");

endmodule
